[design/ase_pkg.sv]
// Package for the ascending sort engine: depth, index widths and beat types.
// No dependencies; imported by ascending_sort_engine.
`timescale 1ns / 1ps
`default_nettype none

package ase_pkg;

    localparam int DEPTH = 64;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int VAL_W = 32;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic                    last;
    } ase_item_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] sorted_value;
        logic                    final_res;
        logic                    overflow;
    } ase_result_t;

endpackage

`default_nettype wire

[design/ascending_sort_engine.sv]
// Ascending sort engine: collects a set of signed values, sorts them in place, emits them.
// Beats are stored in the element RAM as they are taken; after the closing beat an insertion
// sort over the element RAM orders them in place, paced by the single compare unit and the
// one read / one write port of the RAM. While emitting, each result is read from the RAM,
// then loaded into the output register and held until taken, before the next one is read.
// Reset (rst_n, async, active low) empties the set and the output; RAM content is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module ascending_sort_engine (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 item_valid,
    output logic                item_stall,
    input  wire ase_pkg::ase_item_t item_data,
    output logic                result_valid,
    input  wire                 result_stall,
    output ase_pkg::ase_result_t result_data
);

    import ase_pkg::*;

    // Sequencer codes
    localparam logic [2:0] S_LOAD   = 3'd0;  // take beats into the RAM
    localparam logic [2:0] S_FETCH  = 3'd1;  // read element i
    localparam logic [2:0] S_GETCUR = 3'd2;  // latch element i, read i-1
    localparam logic [2:0] S_CMP    = 3'd3;  // compare neighbor against held element
    localparam logic [2:0] S_PLACE  = 3'd4;  // drop held element at slot 0
    localparam logic [2:0] S_ORD    = 3'd5;  // read first result
    localparam logic [2:0] S_OWAIT  = 3'd6;  // load output register
    localparam logic [2:0] S_OHOLD  = 3'd7;  // hold result until taken

    // Element RAM: one write port, one registered read port
    logic signed [VAL_W-1:0] mem [DEPTH];
    logic signed [VAL_W-1:0] rd_data_reg;
    logic [IDX_W-1:0]        rd_addr;
    logic                    wr_en;
    logic [IDX_W-1:0]        wr_addr;
    logic signed [VAL_W-1:0] wr_data;

    // Sequencer and datapath registers
    logic [2:0]              state_reg, state_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic                    ovf_reg, ovf_next;
    logic [IDX_W-1:0]        i_reg, i_next;
    logic [IDX_W-1:0]        j_reg, j_next;
    logic [IDX_W-1:0]        k_reg, k_next;
    logic signed [VAL_W-1:0] cur_reg, cur_next;
    logic                    out_valid_reg, out_valid_next;
    ase_result_t             out_data_reg, out_data_next;

    logic                    item_acc;
    logic                    res_acc;
    logic                    has_room;
    logic                    i_is_end;
    logic                    k_is_end;
    logic                    greater;

    assign item_stall   = (state_reg != S_LOAD);
    assign item_acc     = item_valid && !item_stall;
    assign result_valid = out_valid_reg;
    assign result_data  = out_data_reg;
    assign res_acc      = out_valid_reg && !result_stall;

    assign has_room = (count_reg < CNT_W'(DEPTH));
    // i is the last index of the set once i + 1 reaches the count
    assign i_is_end = ((CNT_W'(i_reg) + CNT_W'(1)) == count_reg);
    assign k_is_end = ((CNT_W'(k_reg) + CNT_W'(1)) == count_reg);
    // The single compare unit: stored neighbor against the held element
    assign greater  = (rd_data_reg > cur_reg);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        cur_next       = cur_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        rd_addr        = '0;
        wr_en          = 1'b0;
        wr_addr        = '0;
        wr_data        = cur_reg;

        case (state_reg)
            S_LOAD:
            begin
                if (item_acc)
                begin
                    // Store while there is room, otherwise drop and flag the set
                    if (has_room)
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = count_reg[IDX_W-1:0];
                        wr_data    = item_data.value;
                        count_next = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (item_data.last)
                    begin
                        i_next = IDX_W'(1);
                        k_next = '0;
                        // A single element needs no sorting
                        if (count_next == CNT_W'(1))
                        begin
                            state_next = S_ORD;
                        end
                        else
                        begin
                            state_next = S_FETCH;
                        end
                    end
                end
            end

            S_FETCH:
            begin
                rd_addr    = i_reg;
                state_next = S_GETCUR;
            end

            S_GETCUR:
            begin
                cur_next   = rd_data_reg;
                j_next     = i_reg;
                rd_addr    = i_reg - IDX_W'(1);
                state_next = S_CMP;
            end

            S_CMP:
            begin
                wr_en   = 1'b1;
                wr_addr = j_reg;
                if (greater)
                begin
                    // Shift the neighbor up one slot and keep walking down
                    wr_data = rd_data_reg;
                    j_next  = j_reg - IDX_W'(1);
                    if (j_reg == IDX_W'(1))
                    begin
                        state_next = S_PLACE;
                    end
                    else
                    begin
                        rd_addr = j_reg - IDX_W'(2);
                    end
                end
                else
                begin
                    wr_data = cur_reg;
                    i_next  = i_reg + IDX_W'(1);
                    if (i_is_end)
                    begin
                        state_next = S_ORD;
                    end
                    else
                    begin
                        state_next = S_FETCH;
                    end
                end
            end

            S_PLACE:
            begin
                wr_en   = 1'b1;
                wr_addr = '0;
                wr_data = cur_reg;
                i_next  = i_reg + IDX_W'(1);
                if (i_is_end)
                begin
                    state_next = S_ORD;
                end
                else
                begin
                    state_next = S_FETCH;
                end
            end

            S_ORD:
            begin
                rd_addr    = k_reg;
                state_next = S_OWAIT;
            end

            S_OWAIT:
            begin
                out_data_next.sorted_value = rd_data_reg;
                out_data_next.final_res    = k_is_end;
                out_data_next.overflow     = ovf_reg;
                out_valid_next             = 1'b1;
                state_next                 = S_OHOLD;
            end

            S_OHOLD:
            begin
                if (res_acc)
                begin
                    out_valid_next = 1'b0;
                    if (out_data_reg.final_res)
                    begin
                        // Set done: start a fresh one
                        count_next = '0;
                        ovf_next   = 1'b0;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        k_next     = k_reg + IDX_W'(1);
                        rd_addr    = k_reg + IDX_W'(1);
                        state_next = S_OWAIT;
                    end
                end
            end

            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: no reset
    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        out_data_reg <= out_data_next;
    end

    // The store never holds more than DEPTH elements
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("element count beyond depth");

    // No input beat is taken while a result is pending
    a_no_load_while_out: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> item_stall)
        else $error("input accepted while a result is pending");

    // The insertion walk never compares below slot 0
    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMP) |-> (j_reg != '0))
        else $error("insertion walk below slot zero");

    // Taking the closing result empties the set
    a_set_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (res_acc && result_data.final_res) |=> (count_reg == '0 && !ovf_reg
                                                && state_reg == S_LOAD))
        else $error("set not cleared after final result");

endmodule

`default_nettype wire
